// File: hdl/bcb_pkg.sv
// ----------------------------------------------------------------------------
// bcb_pkg
// Shared types and constants for the block class bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

package bcb_pkg;

   localparam int MAX_BLOCKS = 65536;
   localparam int BLK_W      = $clog2(MAX_BLOCKS);
   localparam int EXT_W      = 25;

   localparam int KIND_W  = 2;
   localparam int IDX_W   = 16;
   localparam int BYTES_W = 24;
   localparam int BSIZE_W = 17;
   localparam int MARK_W  = 2;
   localparam int TOTAL_W = 32;

   localparam logic [BSIZE_W-1:0] BSIZE_RESET = 17'd512;
   localparam logic [BSIZE_W-1:0] BSIZE_MIN   = 17'd1;

   localparam logic [MARK_W-1:0] CODE_HEADER = 2'b11;
   localparam logic [MARK_W-1:0] CODE_DATA   = 2'b01;
   localparam logic [MARK_W-1:0] MARK_NONE   = 2'b00;

   localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RANGE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_GET   = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_MODIFY
   } bcb_state_type;

endpackage

`default_nettype wire

// File: hdl/bcb_ram.sv
// ----------------------------------------------------------------------------
// bcb_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bcb_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/block_class_bitmap.sv
// ----------------------------------------------------------------------------
// block_class_bitmap
// Per-block 2-bit class map (unseen, data, header) with a header mark counter.
// ----------------------------------------------------------------------------
// After reset the map is cleared one entry per cycle over all MAX_BLOCKS
// entries, with busy high. An item is taken when start is high and busy low.
// A set goes from accept through a lookup and a modify state: one read and
// one write-back through the map RAM, whose read data arrives in the cycle
// after the address; a get only reads. A range set does a read-modify-write
// for each marked block in turn. An item that touches no block (unused kind,
// empty range) is answered straight from idle. Each item gives exactly
// one result, shown with rsp_strobe for one cycle after the item finishes;
// the result port has no backpressure. csr_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module block_class_bitmap (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [bcb_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [bcb_pkg::IDX_W-1:0]       req_block_index,
   input  wire logic                            req_is_header,
   input  wire logic [bcb_pkg::BYTES_W-1:0]     req_range_bytes,
   output logic                                 rsp_strobe,
   output logic      [bcb_pkg::MARK_W-1:0]      rsp_mark,
   output logic      [bcb_pkg::TOTAL_W-1:0]     rsp_header_total,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [bcb_pkg::BSIZE_W-1:0]     csr_block_size
);

   localparam logic [bcb_pkg::BLK_W-1:0] LAST_BLK =
      bcb_pkg::BLK_W'(bcb_pkg::MAX_BLOCKS - 1);
   localparam logic [bcb_pkg::EXT_W-1:0] MAX_EXT =
      bcb_pkg::EXT_W'(bcb_pkg::MAX_BLOCKS);

   bcb_pkg::bcb_state_type state_ff, state_in;

   logic [bcb_pkg::KIND_W-1:0]  kind_ff, kind_in;
   logic                        hdr_ff, hdr_in;
   logic [bcb_pkg::BYTES_W-1:0] rem_ff, rem_in;
   logic [bcb_pkg::BLK_W-1:0]   cur_ff, cur_in;
   logic [bcb_pkg::BSIZE_W-1:0] bsize_ff;
   logic [bcb_pkg::TOTAL_W-1:0] cnt_ff, cnt_in;
   logic                        rsp_strobe_ff, rsp_strobe_in;
   logic [bcb_pkg::MARK_W-1:0]  rsp_mark_ff, rsp_mark_in;
   logic [bcb_pkg::TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   logic                        wr_en;
   logic [bcb_pkg::MARK_W-1:0]  wr_data;
   logic [bcb_pkg::MARK_W-1:0]  rd_data;
   logic [bcb_pkg::MARK_W-1:0]  code;
   logic [bcb_pkg::MARK_W-1:0]  new_mark;
   logic [bcb_pkg::BSIZE_W-1:0] bsize_eff;
   logic [bcb_pkg::EXT_W-1:0]   idx_ext;
   logic                        idx_ok;
   logic                        go;
   logic [bcb_pkg::TOTAL_W-1:0] cnt_next;

   bcb_ram #(
      .WIDTH (bcb_pkg::MARK_W),
      .DEPTH (bcb_pkg::MAX_BLOCKS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_ff),
      .wr_data (wr_data),
      .rd_addr (cur_ff),
      .rd_data (rd_data)
   );

   assign code      = hdr_ff ? bcb_pkg::CODE_HEADER : bcb_pkg::CODE_DATA;
   assign new_mark  = rd_data | code;
   assign bsize_eff = (bsize_ff == '0) ? bcb_pkg::BSIZE_MIN : bsize_ff;
   assign idx_ext   = bcb_pkg::EXT_W'(req_block_index);
   assign idx_ok    = idx_ext < MAX_EXT;
   assign go        = idx_ok && ((req_kind == bcb_pkg::KIND_SET) ||
                                 (req_kind == bcb_pkg::KIND_GET) ||
                                 ((req_kind == bcb_pkg::KIND_RANGE) &&
                                  (req_range_bytes != '0)));
   assign cnt_next  = hdr_ff ? cnt_ff + 32'd1 : cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bcb_pkg::ST_CLEAR;
         cur_ff        <= '0;
         cnt_ff        <= '0;
         bsize_ff      <= bcb_pkg::BSIZE_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            bsize_ff <= csr_block_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      hdr_ff       <= hdr_in;
      rem_ff       <= rem_in;
      rsp_mark_ff  <= rsp_mark_in;
      rsp_total_ff <= rsp_total_in;
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      hdr_in        = hdr_ff;
      rem_in        = rem_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_mark_in   = rsp_mark_ff;
      rsp_total_in  = rsp_total_ff;
      wr_en         = 1'b0;
      wr_data       = bcb_pkg::MARK_NONE;

      unique case (state_ff)
         bcb_pkg::ST_CLEAR: begin
            wr_en = 1'b1;
            if (cur_ff == LAST_BLK) begin
               cur_in   = '0;
               state_in = bcb_pkg::ST_IDLE;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end
         bcb_pkg::ST_IDLE: begin
            if (start) begin
               kind_in = req_kind;
               hdr_in  = req_is_header;
               rem_in  = req_range_bytes;
               cur_in  = bcb_pkg::BLK_W'(idx_ext);
               if (go) begin
                  state_in = bcb_pkg::ST_LOOKUP;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_mark_in   = bcb_pkg::MARK_NONE;
                  rsp_total_in  = cnt_ff;
               end
            end
         end
         bcb_pkg::ST_LOOKUP: begin
            state_in = bcb_pkg::ST_MODIFY;
         end
         bcb_pkg::ST_MODIFY: begin
            if (kind_ff == bcb_pkg::KIND_GET) begin
               state_in      = bcb_pkg::ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_mark_in   = rd_data;
               rsp_total_in  = cnt_ff;
            end else begin
               wr_en   = 1'b1;
               wr_data = new_mark;
               cnt_in  = cnt_next;
               if ((kind_ff == bcb_pkg::KIND_RANGE) &&
                   (rem_ff > bcb_pkg::BYTES_W'(bsize_eff)) &&
                   (cur_ff != LAST_BLK)) begin
                  rem_in   = rem_ff - bcb_pkg::BYTES_W'(bsize_eff);
                  cur_in   = cur_ff + 1'b1;
                  state_in = bcb_pkg::ST_LOOKUP;
               end else begin
                  state_in      = bcb_pkg::ST_IDLE;
                  rsp_strobe_in = 1'b1;
                  rsp_mark_in   = new_mark;
                  rsp_total_in  = cnt_next;
               end
            end
         end
         default: begin
            state_in = bcb_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != bcb_pkg::ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_mark         = rsp_mark_ff;
   assign rsp_header_total = rsp_total_ff;

`ifndef SYNTHESIS
   a_strobe_when_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while an item is still in work");

   a_strobe_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == bcb_pkg::ST_MODIFY) || $past(start && !busy))
      else $error("result strobe without a finished item");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (cnt_ff != $past(cnt_ff))) |->
         (cnt_ff == $past(cnt_ff) + 32'd1))
      else $error("header count moved by more than one");

   a_total_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_header_total == cnt_ff))
      else $error("reported header total differs from counter");
`endif

endmodule

`default_nettype wire
